>>> hdl/bpgc_pkg.sv
// shared types and codes for the button press gesture classifier
package bpgc_pkg;

   localparam int unsigned NOW_W  = 32;
   localparam int unsigned CFG_W  = 16;
   localparam int unsigned IDX_W  = 1;
   localparam int unsigned REQ_DATA_W = 40;
   localparam int unsigned RSP_DATA_W = 8;

   localparam logic OP_EDGE = 1'b0;
   localparam logic OP_TICK = 1'b1;

   localparam logic [IDX_W-1:0] REG_LONG_PRESS = 1'd0;
   localparam logic [IDX_W-1:0] REG_DOUBLE_GAP = 1'd1;

   localparam logic [CFG_W-1:0] LONG_PRESS_RESET = 16'd1000;
   localparam logic [CFG_W-1:0] DOUBLE_GAP_RESET = 16'd300;

   typedef logic [1:0] event_type;

   localparam event_type EV_NONE   = 2'd0;
   localparam event_type EV_SINGLE = 2'd1;
   localparam event_type EV_DOUBLE = 2'd2;
   localparam event_type EV_LONG   = 2'd3;

   typedef struct packed {
      logic             opcode;
      logic             pin_level;
      logic [NOW_W-1:0] now_ms;
   } req_payload_type;

   typedef struct packed {
      logic             we;
      logic [IDX_W-1:0] index;
      logic [CFG_W-1:0] wdata;
   } csr_write_type;

endpackage

>>> hdl/button_press_gesture_classifier_unit.sv
// top level of the button press gesture classifier
// a request is held in the input register and its result in the result register
// throughput: one request per cycle unless stalled, set by one time compare per item
// while the result register waits downstream the input register takes one more request
// reset is synchronous and active high: state idle, edge time zero, no pending event,
// long press 1000 ms and double gap 300 ms
module button_press_gesture_classifier_unit
   import bpgc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // pin_level, now_ms, zero pad
   input  logic                  req_tuser,  // opcode
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // event_res, zero pad
   input  logic                  csr_we,
   input  logic [IDX_W-1:0]      csr_index,
   input  logic [CFG_W-1:0]      csr_wdata
);

   req_payload_type req_payload;
   req_payload_type held_payload;
   csr_write_type   csr;
   logic            advance;
   logic            out_ready;
   event_type       event_res;

   assign req_payload.opcode    = req_tuser;
   assign req_payload.pin_level = req_tdata[0];
   assign req_payload.now_ms    = req_tdata[NOW_W:1];

   assign csr.we    = csr_we;
   assign csr.index = csr_index;
   assign csr.wdata = csr_wdata;

   bpgc_in_stage u_in_stage (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_payload  (req_payload),
      .out_ready    (out_ready),
      .advance      (advance),
      .held_payload (held_payload)
   );

   bpgc_core u_core (
      .clock     (clock),
      .reset     (reset),
      .csr       (csr),
      .advance   (advance),
      .payload   (held_payload),
      .event_res (event_res)
   );

   bpgc_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .event_res  (event_res),
      .out_ready  (out_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

>>> hdl/bpgc_in_stage.sv
// input register stage holding one request until the result register can take it
module bpgc_in_stage
   import bpgc_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   output logic            req_tready,
   input  req_payload_type req_payload,
   input  logic            out_ready,
   output logic            advance,
   output req_payload_type held_payload
);

   logic            in_valid_ff;
   logic            in_valid_in;
   req_payload_type payload_ff;
   logic            req_fire;

   assign advance    = in_valid_ff && out_ready;
   assign req_tready = !in_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;
   assign in_valid_in = req_fire || (in_valid_ff && !advance);
   assign held_payload = payload_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         payload_ff <= req_payload;
      end
   end

endmodule

>>> hdl/bpgc_core.sv
// gesture state machine, edge timestamp, pending flag and timing registers
module bpgc_core
   import bpgc_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  csr_write_type   csr,
   input  logic            advance,
   input  req_payload_type payload,
   output event_type       event_res
);

   localparam logic [1:0] ST_IDLE    = 2'd0;
   localparam logic [1:0] ST_PRESSED = 2'd1;
   localparam logic [1:0] ST_WAIT    = 2'd2;
   localparam logic [1:0] ST_SECOND  = 2'd3;

   logic [1:0]       state_ff,     state_in;
   logic [NOW_W-1:0] edge_time_ff, edge_time_in;
   logic             pending_ff,   pending_in;
   logic [CFG_W-1:0] long_ms_ff;
   logic [CFG_W-1:0] gap_ms_ff;
   logic [NOW_W-1:0] elapsed;
   logic             long_hit;
   logic             gap_hit;

   // wrapping difference since the stored edge time
   assign elapsed  = payload.now_ms - edge_time_ff;
   assign long_hit = elapsed >= {{(NOW_W-CFG_W){1'b0}}, long_ms_ff};
   assign gap_hit  = elapsed >= {{(NOW_W-CFG_W){1'b0}}, gap_ms_ff};

   always_comb begin
      state_in     = state_ff;
      edge_time_in = edge_time_ff;
      pending_in   = pending_ff;
      event_res    = EV_NONE;
      if (payload.opcode == OP_EDGE) begin
         unique case (state_ff)
            ST_IDLE: begin
               if (!payload.pin_level) begin
                  state_in     = ST_PRESSED;
                  edge_time_in = payload.now_ms;
               end
            end
            ST_PRESSED: begin
               if (payload.pin_level) begin
                  state_in     = ST_WAIT;
                  edge_time_in = payload.now_ms;
               end
            end
            ST_WAIT: begin
               if (!payload.pin_level) begin
                  state_in     = ST_SECOND;
                  edge_time_in = payload.now_ms;
               end
            end
            default: begin
               // release of the second press, edge time kept
               if (payload.pin_level) begin
                  pending_in = 1'b1;
                  state_in   = ST_IDLE;
               end
            end
         endcase
      end else begin
         // a pending double press goes out first and blocks other checks
         priority if (pending_ff) begin
            pending_in = 1'b0;
            event_res  = EV_DOUBLE;
         end else if (state_ff == ST_PRESSED && long_hit) begin
            state_in  = ST_IDLE;
            event_res = EV_LONG;
         end else if (state_ff == ST_WAIT && gap_hit) begin
            state_in  = ST_IDLE;
            event_res = EV_SINGLE;
         end else begin
            event_res = EV_NONE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         edge_time_ff <= '0;
         pending_ff   <= 1'b0;
      end else if (advance) begin
         state_ff     <= state_in;
         edge_time_ff <= edge_time_in;
         pending_ff   <= pending_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         long_ms_ff <= LONG_PRESS_RESET;
         gap_ms_ff  <= DOUBLE_GAP_RESET;
      end else if (csr.we) begin
         unique case (csr.index)
            REG_LONG_PRESS: long_ms_ff <= csr.wdata;
            REG_DOUBLE_GAP: gap_ms_ff  <= csr.wdata;
            default: ;
         endcase
      end
   end

endmodule

>>> hdl/bpgc_out_stage.sv
// result register holding one event until the downstream side takes it
module bpgc_out_stage
   import bpgc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  event_type             event_res,
   output logic                  out_ready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic      out_valid_ff, out_valid_in;
   event_type event_ff;

   assign out_ready    = !out_valid_ff || rsp_tready;
   assign out_valid_in = advance || (out_valid_ff && !rsp_tready);
   assign rsp_tvalid   = out_valid_ff;
   assign rsp_tdata    = {{(RSP_DATA_W-2){1'b0}}, event_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         event_ff <= event_res;
      end
   end

endmodule

>>> hdl/bpgc_checker.sv
// port-level checks for the gesture classifier and their bind to the top level
module bpgc_checker
   import bpgc_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   event_type last_ev_ff;

   // last event handed downstream
   always_ff @(posedge clock) begin
      if (reset) begin
         last_ev_ff <= EV_NONE;
      end else if (rsp_tvalid && rsp_tready) begin
         last_ev_ff <= rsp_tdata[1:0];
      end
   end

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request refused with empty result register");

   // every gesture returns to idle, so the next result needs an edge first
   a_no_repeat_event: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && last_ev_ff != EV_NONE
      |-> rsp_tdata[1:0] != last_ev_ff)
      else $error("same gesture reported twice in a row");

endmodule

bind button_press_gesture_classifier_unit bpgc_checker u_bpgc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

>>> bench/testbench.sv
// self-checking testbench for the button press gesture classifier
module testbench;
   import bpgc_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned SEG_ITEMS   = 215;
   localparam int unsigned MAX_REPORTS = 50;

   typedef enum logic [1:0] {G_IDLE, G_PRESSED, G_WAIT, G_SECOND} gesture_state_type;

   // predicts the event of every accepted request and checks results in order
   class gesture_scoreboard_type;
      gesture_state_type gstate;
      logic [NOW_W-1:0]  edge_ms;
      logic              double_pending;
      logic [CFG_W-1:0]  long_ms;
      logic [CFG_W-1:0]  gap_ms;
      event_type         expected_events[$];
      int unsigned       failures;

      function new();
         gstate         = G_IDLE;
         edge_ms        = '0;
         double_pending = 1'b0;
         long_ms        = LONG_PRESS_RESET;
         gap_ms         = DOUBLE_GAP_RESET;
         failures       = 0;
      endfunction

      function void set_register(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] value);
         if (idx == REG_LONG_PRESS) begin
            long_ms = value;
         end else if (idx == REG_DOUBLE_GAP) begin
            gap_ms = value;
         end
      endfunction

      function void note_request(logic op, logic level, logic [NOW_W-1:0] now);
         event_type        ev;
         logic [NOW_W-1:0] held;
         ev   = EV_NONE;
         held = now - edge_ms;
         if (op == OP_EDGE) begin
            case (gstate)
               G_IDLE: begin
                  if (!level) begin
                     gstate  = G_PRESSED;
                     edge_ms = now;
                  end
               end
               G_PRESSED: begin
                  if (level) begin
                     gstate  = G_WAIT;
                     edge_ms = now;
                  end
               end
               G_WAIT: begin
                  if (!level) begin
                     gstate  = G_SECOND;
                     edge_ms = now;
                  end
               end
               default: begin
                  // second release keeps the edge time
                  if (level) begin
                     double_pending = 1'b1;
                     gstate         = G_IDLE;
                  end
               end
            endcase
         end else if (double_pending) begin
            double_pending = 1'b0;
            ev             = EV_DOUBLE;
         end else if (gstate == G_PRESSED && held >= NOW_W'(long_ms)) begin
            gstate = G_IDLE;
            ev     = EV_LONG;
         end else if (gstate == G_WAIT && held >= NOW_W'(gap_ms)) begin
            gstate = G_IDLE;
            ev     = EV_SINGLE;
         end
         expected_events.push_back(ev);
      endfunction

      function void check_event(logic [RSP_DATA_W-1:0] data);
         event_type want;
         if (expected_events.size() == 0) begin
            failures++;
            if (failures <= MAX_REPORTS)
               $display("%0t: unexpected result, expected none, actual event %0d",
                        $time, data[1:0]);
         end else begin
            want = expected_events.pop_front();
            if (data[1:0] !== want) begin
               failures++;
               if (failures <= MAX_REPORTS)
                  $display("%0t: event mismatch, expected %0d, actual %0d",
                           $time, want, data[1:0]);
            end
         end
      endfunction

      function int unsigned outstanding();
         return expected_events.size();
      endfunction
   endclass

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  req_tuser  = OP_EDGE;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we     = 1'b0;
   logic [IDX_W-1:0]      csr_index  = REG_LONG_PRESS;
   logic [CFG_W-1:0]      csr_wdata  = '0;

   gesture_scoreboard_type ledger = new();

   int unsigned      tx_idle_pct = 0;
   int unsigned      rx_idle_pct = 0;
   int unsigned      items_sent  = 0;
   int unsigned      cycle_count = 0;
   logic [NOW_W-1:0] t_ms;
   int unsigned      long_cfg = LONG_PRESS_RESET;
   int unsigned      gap_cfg  = DOUBLE_GAP_RESET;

   button_press_gesture_classifier_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("** button_press_gesture_classifier_unit: FAILED **");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
   end

   // results are checked before the request of the same edge is noted
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready)
            ledger.check_event(rsp_tdata);
         if (req_tvalid && req_tready)
            ledger.note_request(req_tuser, req_tdata[0], req_tdata[NOW_W:1]);
      end
   end

   task automatic send_request(input logic op, input logic level,
                               input logic [NOW_W-1:0] now);
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {{(REQ_DATA_W-NOW_W-1){1'b0}}, now, level};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   // hold off until every outstanding request has its result
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (ledger.outstanding() != 0) @(posedge clock);
   endtask

   task automatic write_register(input logic [IDX_W-1:0] idx, input int unsigned value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CFG_W'(value);
      @(posedge clock);
      csr_we    <= 1'b0;
      ledger.set_register(idx, CFG_W'(value));
      if (idx == REG_LONG_PRESS)
         long_cfg = value;
      else
         gap_cfg = value;
   endtask

   // a delay clustered around a threshold, sometimes anywhere up to twice it
   function automatic int unsigned near_delay(input int unsigned thr);
      case ($urandom_range(0, 3))
         0:       return (thr > 0) ? thr - 1 : 0;
         1:       return thr;
         2:       return thr + $urandom_range(0, 3);
         default: return $urandom_range(0, 2 * thr);
      endcase
   endfunction

   // one or two presses with ticks around the hold and gap limits
   task automatic play_gesture();
      logic [NOW_W-1:0] t_edge;
      int unsigned      presses;
      presses = $urandom_range(1, 2);
      for (int p = 0; p < presses; p++) begin
         t_edge = t_ms;
         send_request(OP_EDGE, 1'b0, t_edge);
         repeat ($urandom_range(0, 2))
            send_request(OP_TICK, 1'($urandom_range(0, 1)), t_edge + near_delay(long_cfg));
         t_ms = t_edge + near_delay(long_cfg);
         send_request(OP_EDGE, 1'b1, t_ms);
         t_edge = t_ms;
         repeat ($urandom_range(0, 2))
            send_request(OP_TICK, 1'($urandom_range(0, 1)), t_edge + near_delay(gap_cfg));
         if (p + 1 < presses)
            t_ms = t_edge + $urandom_range(0, gap_cfg);
         else
            t_ms = t_edge + near_delay(gap_cfg);
      end
      repeat ($urandom_range(1, 2))
         send_request(OP_TICK, 1'($urandom_range(0, 1)), t_ms);
      t_ms = t_ms + $urandom_range(1, 70000);
   endtask

   initial begin
      int unsigned target;
      logic        paused;
      paused = 1'b0;
      t_ms   = $urandom();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part at the reset settings, crossing the time wrap
      send_request(OP_TICK, 1'b0, 32'h0000_0000);
      send_request(OP_EDGE, 1'b1, 32'h0000_0005);      // release while idle
      send_request(OP_EDGE, 1'b0, 32'hFFFF_FF00);
      send_request(OP_TICK, 1'b1, 32'h0000_02E7);      // one short of a long press
      send_request(OP_TICK, 1'b0, 32'h0000_02E8);      // long press exactly
      send_request(OP_EDGE, 1'b1, 32'h0000_0300);      // late release after long press
      send_request(OP_EDGE, 1'b0, 32'h0000_1000);
      send_request(OP_EDGE, 1'b1, 32'h0000_1010);
      send_request(OP_TICK, 1'b1, 32'h0000_1010 + 299);
      send_request(OP_TICK, 1'b0, 32'h0000_1010 + 300); // single press
      send_request(OP_EDGE, 1'b0, 32'h0000_2000);
      send_request(OP_EDGE, 1'b1, 32'h0000_2010);
      send_request(OP_EDGE, 1'b0, 32'h0000_2020);
      send_request(OP_TICK, 1'b1, 32'h0000_5000);      // second press held
      send_request(OP_EDGE, 1'b0, 32'h0000_2025);
      send_request(OP_EDGE, 1'b1, 32'h0000_2030);      // double press pending
      send_request(OP_EDGE, 1'b0, 32'h0000_2040);      // pending survives a new press
      send_request(OP_TICK, 1'b1, 32'hFFFF_FFFF);
      send_request(OP_TICK, 1'b0, 32'h0000_2040 + 1000);
      send_request(OP_EDGE, 1'b0, 32'hFFFF_FFFF);
      send_request(OP_EDGE, 1'b1, 32'h0000_0000);
      send_request(OP_TICK, 1'b1, 32'h0000_012B);      // press crosses the time wrap, gap one short of 300
      send_request(OP_TICK, 1'b0, 32'h0000_012C);

      for (int seg = 0; seg < 6; seg++) begin
         drain();
         if (seg < 2) begin
            tx_idle_pct = 15;
            rx_idle_pct = 78;
         end else if (seg < 4) begin
            tx_idle_pct = 78;
            rx_idle_pct = 15;
         end else begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
         end
         case (seg)
            0: begin
               write_register(REG_LONG_PRESS, 1);
               write_register(REG_DOUBLE_GAP, 1);
            end
            1: begin
               write_register(REG_LONG_PRESS, 65535);
               write_register(REG_DOUBLE_GAP, 65535);
            end
            2: begin
               write_register(REG_LONG_PRESS, $urandom_range(1, 65535));
               write_register(REG_DOUBLE_GAP, $urandom_range(1, 65535));
            end
            3: begin
               write_register(REG_LONG_PRESS, 40);
               write_register(REG_DOUBLE_GAP, 15);
            end
            4: begin
               write_register(REG_LONG_PRESS, 1);
               write_register(REG_DOUBLE_GAP, 65535);
            end
            default: begin
               write_register(REG_LONG_PRESS, $urandom_range(1, 200));
               write_register(REG_DOUBLE_GAP, $urandom_range(1, 200));
            end
         endcase
         target = items_sent + SEG_ITEMS;
         while (items_sent < target) begin
            if (seg == 1 && !paused && items_sent + 100 >= target) begin
               drain();
               paused = 1'b1;
            end
            case ($urandom_range(0, 9))
               0: send_request(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                               $urandom());
               1: send_request(OP_EDGE, 1'($urandom_range(0, 1)),
                               t_ms + $urandom_range(0, 3));
               default: play_gesture();
            endcase
         end
      end

      drain();
      repeat (5) @(posedge clock);
      if (ledger.failures == 0) begin
         $display("** button_press_gesture_classifier_unit: PASSED **");
      end else begin
         $display("** button_press_gesture_classifier_unit: FAILED **");
      end
      $finish;
   end

endmodule
